@@ rtl/core/rskr_pkg.sv @@
package rskr_pkg;

  // default number of records held
  localparam int unsigned DefaultDepth = 16;

  // opcodes of an input transaction
  localparam logic [1:0] OpPush   = 2'd0;
  localparam logic [1:0] OpPop    = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusEmpty    = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  // per-cycle action of every cell in the chain
  localparam logic [1:0] CellHold   = 2'd0;
  localparam logic [1:0] CellPush   = 2'd1;
  localparam logic [1:0] CellPop    = 2'd2;
  localparam logic [1:0] CellRemove = 2'd3;

  // width of the entry count field on the result
  localparam int unsigned CountFieldW = 5;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic [31:0]        price_bits;
  } record_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] key;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic [31:0]        price_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [31:0]     out_key;
    logic [63:0]            out_name_low;
    logic [63:0]            out_name_mid;
    logic [31:0]            out_name_high;
    logic [31:0]            out_price_bits;
    logic [CountFieldW-1:0] entry_count;
    logic                   is_empty;
  } out_item_t;

  // control broadcast from the sequencer to all cells
  typedef struct packed {
    logic [1:0] mode;
    logic       compare;
  } cell_ctrl_t;

endpackage

@@ rtl/core/rskr_cell.sv @@
module rskr_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rskr_pkg::cell_ctrl_t  ctrl_i,
  input  logic                  occupied_i,
  input  logic signed [31:0]    search_key_i,
  input  rskr_pkg::record_t     rec_above_i,
  input  rskr_pkg::record_t     rec_below_i,
  input  logic                  hit_i,
  output logic                  hit_o,
  output rskr_pkg::record_t     rec_o
);

  rskr_pkg::record_t rec_q;
  logic              match_q;

  // a match here or in any cell nearer the top
  assign hit_o = hit_i | match_q;
  assign rec_o = rec_q;

  // record storage, shifts one step toward or away from the top
  always_ff @(posedge clk_i) begin
    case (ctrl_i.mode)
      rskr_pkg::CellPush: rec_q <= rec_above_i;
      rskr_pkg::CellPop:  rec_q <= rec_below_i;
      rskr_pkg::CellRemove: begin
        if (hit_o) begin
          rec_q <= rec_below_i;
        end
      end
      default: rec_q <= rec_q;
    endcase
  end

  // registered key compare for removal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.compare) begin
      match_q <= occupied_i && (rec_q.key == search_key_i);
    end
  end

endmodule

@@ rtl/core/record_stack_with_keyed_removal.sv @@
// Bounded LIFO stack of records with removal of the topmost record by key.
// Input channel in_valid_i / in_stall_o / in_data_i carries one operation per
// transaction: push, pop, or remove by key. Output channel out_valid_o /
// out_stall_i / out_data_o returns exactly one result per operation with the
// status, the popped record (zero otherwise), the count and an empty flag.
// Records live in a chain of cells, the top of stack in cell 0; push and pop
// shift the whole chain one step. Push and pop present their result from the
// execute step; remove first passes a compare step (the parallel key compare in
// every cell) and then the execute step (the shift). A new operation is taken
// only once the previous one has been executed, not while one is in progress;
// a single sequencer drives the cell chain.
// When the receiver stalls, the result stays in the output register and the
// next operation may be accepted; it waits in its execute step until the
// output register is free. Reset empties the stack and drops any result.
module record_stack_with_keyed_removal #(
  parameter int unsigned StackDepth = rskr_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rskr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rskr_pkg::out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCmp  = 2'd1;
  localparam logic [1:0] StExec = 2'd2;

  logic [1:0]          state_q, state_d;
  rskr_pkg::in_item_t  item_q;
  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q, out_valid_d;
  rskr_pkg::out_item_t out_q, out_d;

  rskr_pkg::cell_ctrl_t ctrl;
  rskr_pkg::record_t    rec [StackDepth];
  rskr_pkg::record_t    new_rec;
  logic [StackDepth:0]  hit;
  logic                 out_free;
  logic                 in_fire;
  logic                 found;
  logic                 is_full;
  logic                 is_empty_now;

  assign in_stall_o  = (state_q != StIdle);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign is_full      = (count_q == CntW'(StackDepth));
  assign is_empty_now = (count_q == '0);
  assign found        = hit[StackDepth];

  assign new_rec.key        = item_q.key;
  assign new_rec.name_low   = item_q.name_low;
  assign new_rec.name_mid   = item_q.name_mid;
  assign new_rec.name_high  = item_q.name_high;
  assign new_rec.price_bits = item_q.price_bits;

  // chain of record cells, cell 0 is the top of stack
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic occupied;
    assign occupied = (CntW'(i) < count_q);
    rskr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied),
      .search_key_i (item_q.key),
      .rec_above_i  ((i == 0) ? new_rec : rec[(i == 0) ? 0 : i - 1]),
      .rec_below_i  ((i == StackDepth - 1) ? rec[i] : rec[(i == StackDepth - 1) ? i : i + 1]),
      .hit_i        (hit[i]),
      .hit_o        (hit[i+1]),
      .rec_o        (rec[i])
    );
  end

  // sequencer and result formation
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ctrl.mode    = rskr_pkg::CellHold;
    ctrl.compare = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = (in_data_i.opcode == rskr_pkg::OpRemove) ? StCmp : StExec;
        end
      end
      StCmp: begin
        ctrl.compare = 1'b1;
        state_d      = StExec;
      end
      StExec: begin
        if (out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = rskr_pkg::StatusOk;
          case (item_q.opcode)
            rskr_pkg::OpPush: begin
              if (is_full) begin
                out_d.status = rskr_pkg::StatusFull;
              end else begin
                ctrl.mode = rskr_pkg::CellPush;
                count_d   = count_q + CntW'(1);
              end
            end
            rskr_pkg::OpPop: begin
              if (is_empty_now) begin
                out_d.status = rskr_pkg::StatusEmpty;
              end else begin
                ctrl.mode            = rskr_pkg::CellPop;
                count_d              = count_q - CntW'(1);
                out_d.out_key        = rec[0].key;
                out_d.out_name_low   = rec[0].name_low;
                out_d.out_name_mid   = rec[0].name_mid;
                out_d.out_name_high  = rec[0].name_high;
                out_d.out_price_bits = rec[0].price_bits;
              end
            end
            rskr_pkg::OpRemove: begin
              if (found) begin
                ctrl.mode = rskr_pkg::CellRemove;
                count_d   = count_q - CntW'(1);
              end else begin
                out_d.status = rskr_pkg::StatusNotFound;
              end
            end
            default: out_d.status = rskr_pkg::StatusOk;
          endcase
          out_d.entry_count = rskr_pkg::CountFieldW'(count_d);
          out_d.is_empty    = (count_d == '0);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  // count stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(StackDepth))
    else $error("entry count exceeds stack depth");

  // a new result comes only from the execute step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StExec)
    else $error("result produced outside execute step");

  // an accepted transaction leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> state_q != StIdle)
    else $error("accepted transaction not started");

  // a pending result agrees with the held count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.is_empty == (count_q == '0))
    else $error("empty flag disagrees with count");

  // full status only when every cell is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == rskr_pkg::StatusFull) |-> is_full)
    else $error("full status with free cells");

endmodule

@@ verif/record_stack_with_keyed_removal_test.sv @@
`timescale 1ns / 100ps

module record_stack_with_keyed_removal_test;

  localparam int unsigned Depth      = rskr_pkg::DefaultDepth;
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam int          RandomOps  = 1700;
  localparam int          IdlePct    = 36;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  rskr_pkg::in_item_t  in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  rskr_pkg::out_item_t out_data_o;

  // directed stimulus row, with a typed-in result where it is obvious
  typedef struct {
    rskr_pkg::in_item_t  item;
    bit                  typed;
    rskr_pkg::out_item_t want;
  } plan_row_t;

  plan_row_t           plan[$];
  rskr_pkg::out_item_t pending_results[$];
  rskr_pkg::record_t   stack_rec[Depth];
  int                  stack_fill = 0;
  int                  mismatch_count = 0;
  bit                  calm = 1'b0;

  record_stack_with_keyed_removal u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("record_stack_with_keyed_removal regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // stack behavior: applies one operation and returns its result
  function automatic rskr_pkg::out_item_t predict_stack_op(input rskr_pkg::in_item_t it);
    rskr_pkg::out_item_t r;
    int hit;
    r = '0;
    r.status = rskr_pkg::StatusOk;
    hit = -1;
    case (it.opcode)
      rskr_pkg::OpPush: begin
        if (stack_fill >= Depth) begin
          r.status = rskr_pkg::StatusFull;
        end else begin
          stack_rec[stack_fill].key        = it.key;
          stack_rec[stack_fill].name_low   = it.name_low;
          stack_rec[stack_fill].name_mid   = it.name_mid;
          stack_rec[stack_fill].name_high  = it.name_high;
          stack_rec[stack_fill].price_bits = it.price_bits;
          stack_fill++;
        end
      end
      rskr_pkg::OpPop: begin
        if (stack_fill == 0) begin
          r.status = rskr_pkg::StatusEmpty;
        end else begin
          stack_fill--;
          r.out_key        = stack_rec[stack_fill].key;
          r.out_name_low   = stack_rec[stack_fill].name_low;
          r.out_name_mid   = stack_rec[stack_fill].name_mid;
          r.out_name_high  = stack_rec[stack_fill].name_high;
          r.out_price_bits = stack_rec[stack_fill].price_bits;
        end
      end
      rskr_pkg::OpRemove: begin
        // topmost match wins, records above it close the gap
        for (int i = stack_fill - 1; i >= 0 && hit < 0; i--) begin
          if (stack_rec[i].key == it.key) hit = i;
        end
        if (hit < 0) begin
          r.status = rskr_pkg::StatusNotFound;
        end else begin
          for (int j = hit; j + 1 < stack_fill; j++) stack_rec[j] = stack_rec[j + 1];
          stack_fill--;
        end
      end
      default: ;
    endcase
    r.entry_count = rskr_pkg::CountFieldW'(stack_fill);
    r.is_empty    = (stack_fill == 0);
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic signed [31:0] key,
                         input logic [63:0] nlow, input logic [63:0] nmid,
                         input logic [31:0] nhigh, input logic [31:0] price,
                         input bit typed, input logic [1:0] status, input int count);
    plan_row_t row;
    row.item.opcode     = op;
    row.item.key        = key;
    row.item.name_low   = nlow;
    row.item.name_mid   = nmid;
    row.item.name_high  = nhigh;
    row.item.price_bits = price;
    row.typed           = typed;
    row.want            = '0;
    row.want.status     = status;
    row.want.entry_count = rskr_pkg::CountFieldW'(count);
    row.want.is_empty   = (count == 0);
    plan.push_back(row);
  endtask

  // random operation, biased toward push by push_pct
  function automatic rskr_pkg::in_item_t random_item(input int push_pct);
    rskr_pkg::in_item_t it;
    it.name_low   = {$urandom, $urandom};
    it.name_mid   = {$urandom, $urandom};
    it.name_high  = $urandom;
    it.price_bits = $urandom;
    if ($urandom_range(99) < 3) begin
      it.opcode = OpUnused;
    end else if ($urandom_range(99) < push_pct) begin
      it.opcode = rskr_pkg::OpPush;
    end else if ($urandom_range(1) == 0) begin
      it.opcode = rskr_pkg::OpPop;
    end else begin
      it.opcode = rskr_pkg::OpRemove;
    end
    // small key pool so that duplicates and remove hits are common
    if (it.opcode == rskr_pkg::OpRemove && stack_fill > 0 && $urandom_range(99) < 70) begin
      it.key = stack_rec[$urandom_range(stack_fill - 1)].key;
    end else begin
      case ($urandom_range(9))
        0:       it.key = 32'sh8000_0000;
        1:       it.key = 32'sh7fff_ffff;
        2:       it.key = -32'sd1;
        3, 4:    it.key = $urandom;
        default: it.key = $urandom_range(7);
      endcase
    end
    return it;
  endfunction

  // sender: random idle, then hold the transaction until accepted
  task automatic issue_op(input rskr_pkg::in_item_t it, input bit typed,
                          input rskr_pkg::out_item_t typed_want);
    rskr_pkg::out_item_t pred;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_stack_op(it);
    pending_results.push_back(typed ? typed_want : pred);
  endtask

  // stop sending until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  // result checker
  always @(posedge clk_i) begin
    rskr_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_data_o.status, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.out_key !== want.out_key)
          report_mismatch("out_key", out_data_o.out_key, want.out_key);
        if (out_data_o.out_name_low !== want.out_name_low)
          report_mismatch("out_name_low", out_data_o.out_name_low, want.out_name_low);
        if (out_data_o.out_name_mid !== want.out_name_mid)
          report_mismatch("out_name_mid", out_data_o.out_name_mid, want.out_name_mid);
        if (out_data_o.out_name_high !== want.out_name_high)
          report_mismatch("out_name_high", out_data_o.out_name_high, want.out_name_high);
        if (out_data_o.out_price_bits !== want.out_price_bits)
          report_mismatch("out_price_bits", out_data_o.out_price_bits, want.out_price_bits);
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_data_o.entry_count, want.entry_count);
        if (out_data_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", out_data_o.is_empty, want.is_empty);
      end
    end
  end

  // stimulus
  initial begin
    int push_pct;
    rskr_pkg::out_item_t no_want;
    no_want  = '0;
    push_pct = 50;

    // empty stack cases, extremes, duplicates, then fill to the top
    add_row(rskr_pkg::OpPop,    0, '0, '0, '0, '0, 1'b1, rskr_pkg::StatusEmpty, 0);
    add_row(rskr_pkg::OpRemove, 0, '0, '0, '0, '0, 1'b1, rskr_pkg::StatusNotFound, 0);
    add_row(OpUnused, 0, '0, '0, '0, '0, 1'b1, rskr_pkg::StatusOk, 0);
    add_row(rskr_pkg::OpPush, 32'sh8000_0000, '1, '1, '1, '1, 1'b1, rskr_pkg::StatusOk, 1);
    add_row(rskr_pkg::OpPush, 32'sh7fff_ffff, '0, '0, '0, '0, 1'b1, rskr_pkg::StatusOk, 2);
    add_row(rskr_pkg::OpPush, 5, 64'h0123_4567_89ab_cdef, 64'h5555_aaaa_5555_aaaa,
            32'h0f0f_f0f0, 32'h3f80_0000, 1'b0, rskr_pkg::StatusOk, 0);
    add_row(rskr_pkg::OpPush, 5, 64'hfedc_ba98_7654_3210, 64'haaaa_5555_aaaa_5555,
            32'hf0f0_0f0f, 32'hbf80_0000, 1'b0, rskr_pkg::StatusOk, 0);
    add_row(rskr_pkg::OpRemove, 5,  '0, '0, '0, '0, 1'b0, rskr_pkg::StatusOk, 0);
    add_row(rskr_pkg::OpRemove, 99, '0, '0, '0, '0, 1'b1, rskr_pkg::StatusNotFound, 3);
    for (int i = 0; i < Depth - 3; i++) begin
      add_row(rskr_pkg::OpPush, 100 + i, {$urandom, $urandom}, {$urandom, $urandom},
              $urandom, $urandom, 1'b0, rskr_pkg::StatusOk, 0);
    end
    add_row(rskr_pkg::OpPush, 1, '0, '0, '0, '0, 1'b1, rskr_pkg::StatusFull, Depth);
    add_row(rskr_pkg::OpPop,  0, '0, '0, '0, '0, 1'b0, rskr_pkg::StatusOk, 0);
    add_row(rskr_pkg::OpRemove, 32'sh8000_0000, '0, '0, '0, '0, 1'b0,
            rskr_pkg::StatusOk, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) issue_op(plan[i].item, plan[i].typed, plan[i].want);
    drain_results();

    // random part in phases that swing the stack between full and empty
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      calm = (n >= 700 && n < 1000);
      if (n == 1100) drain_results();
      issue_op(random_item(push_pct), 1'b0, no_want);
    end
    calm = 1'b0;
    drain_results();
    repeat (12) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("record_stack_with_keyed_removal regression: pass");
    end else begin
      $display("record_stack_with_keyed_removal regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rskr_pkg.sv
rtl/core/rskr_cell.sv
rtl/core/record_stack_with_keyed_removal.sv
verif/record_stack_with_keyed_removal_test.sv
